[hw/rtl/cir_pkg.sv]
// Shared types, constants and helpers of the collision impulse resolver.
package cir_pkg;

   localparam int NUM_BODIES = 64;
   localparam int BODY_W     = 6;
   localparam int ADDR_W     = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
   localparam int VEL_W      = 32;
   localparam int MASS_W     = 32;
   localparam int BOUNCE_W   = 17;

   localparam logic [BOUNCE_W-1:0] BOUNCE_ONE = 17'd65536;

   // Shared multiply/divide unit geometry.
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 34;
   localparam int PROD_W     = 66;
   localparam int MUL_STEPS  = 32;
   localparam int DIV_STEPS  = 48;
   localparam int CNT_W      = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_IMPULSE = 2'd1,
      KIND_COLLIDE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [BODY_W-1:0]          body_a;
      logic [BODY_W-1:0]          body_b;
      logic signed [VEL_W-1:0]    vec_x;
      logic signed [VEL_W-1:0]    vec_y;
      logic signed [VEL_W-1:0]    vec_z;
      logic [MASS_W-1:0]          load_mass;
      logic [BOUNCE_W-1:0]        load_bounce;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_a_x;
      logic signed [VEL_W-1:0] vel_a_y;
      logic signed [VEL_W-1:0] vel_a_z;
      logic signed [VEL_W-1:0] vel_b_x;
      logic signed [VEL_W-1:0] vel_b_y;
      logic signed [VEL_W-1:0] vel_b_z;
      logic                    applied;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [2:0][VEL_W-1:0] vel;
      logic [MASS_W-1:0]     mass;
      logic [BOUNCE_W-1:0]   bounce;
   } body_rec_type;

   localparam int REC_W = $bits(body_rec_type);

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic                  start;
      alu_op_type            op;
      logic [DIVIDEND_W-1:0] a;
      logic [DIVISOR_W-1:0]  b;
   } alu_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quo;
      logic [PROD_W-1:0]     prod;
   } alu_rsp_type;

   // Body number to table row; a small constant table.
   function automatic logic [ADDR_W-1:0] body_index(input logic [BODY_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2**BODY_W; i++) begin
         if (v == BODY_W'(i)) begin
            r = ADDR_W'(i % NUM_BODIES);
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/cir_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module cir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/cir_alu.sv]
// Shared iterative unit: radix-2 shift-add multiply and restoring divide.
module cir_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  cir_pkg::alu_req_type alu_req,
   output cir_pkg::alu_rsp_type alu_rsp
);
   import cir_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   alu_op_type            op_ff, op_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] x_ff, x_in;
   logic [DIVISOR_W-1:0]  y_ff, y_in;

   logic [DIVISOR_W:0]    mul_sum;
   logic [DIVISOR_W:0]    div_sh;
   logic [DIVISOR_W+1:0]  div_diff;
   logic                  div_ge;

   always_comb begin
      mul_sum  = {1'b0, rem_ff} + (x_ff[0] ? {1'b0, y_ff} : '0);
      div_sh   = {rem_ff, x_ff[DIVIDEND_W-1]};
      div_diff = {1'b0, div_sh} - {2'b00, y_ff};
      div_ge   = !div_diff[DIVISOR_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      x_in    = x_ff;
      y_in    = y_ff;

      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in   = alu_req.op;
         cnt_in  = (alu_req.op == ALU_MUL) ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_STEPS);
         rem_in  = '0;
         x_in    = alu_req.a;
         y_in    = alu_req.b;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               rem_in = mul_sum[DIVISOR_W:1];
               x_in   = {{(DIVIDEND_W-MUL_STEPS){1'b0}}, mul_sum[0], x_ff[MUL_STEPS-1:1]};
            end
            ALU_DIV: begin
               rem_in = div_ge ? div_diff[DIVISOR_W-1:0] : div_sh[DIVISOR_W-1:0];
               x_in   = {x_ff[DIVIDEND_W-2:0], div_ge};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      rem_ff <= rem_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign alu_rsp.busy = busy_ff;
   assign alu_rsp.done = done_ff;
   assign alu_rsp.quo  = x_ff;
   assign alu_rsp.prod = {rem_ff[PROD_W-MUL_STEPS-1:0], x_ff[MUL_STEPS-1:0]};

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !busy_ff) else $error("unit started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held longer than one cycle");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("busy with exhausted step count");
   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a run");

endmodule

[hw/rtl/collision_impulse_resolver_unit.sv]
// Top level of the collision impulse resolver: body table, sequencer and shared unit.
//
//  channel | ports                          | direction | moves
//  req     | req_valid req_ready req_data   | in        | load, impulse or collision
//  rsp     | rsp_valid rsp_ready rsp_data   | out       | both bodies' velocities, flags
//
// A transaction runs one at a time. Impulses and collisions run on the shared multiply/divide
// unit, which takes 32 steps per product and 48 per quotient; each operation is issued in
// S_ISSUE and awaited in S_WAIT. Loads and transactions with no work leave the unit idle.
// Reset clears only the control state; the body table holds no defined value until loaded.
// A stalled result waits in the output register; req_ready rises once it is stored there.
module collision_impulse_resolver_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cir_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cir_pkg::rsp_type  rsp_data
);
   import cir_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_A, S_RD_B, S_GOT_B, S_ISSUE, S_WAIT, S_WR,
      S_OUT_A, S_OUT_B, S_OUT_GOT
   } state_type;

   typedef enum logic [2:0] {
      STEP_VN, STEP_INV_A, STEP_INV_B, STEP_NUM, STEP_J, STEP_P, STEP_PUSH
   } step_type;

   localparam logic signed [49:0] MAX32 = 50'sd2147483647;
   localparam logic signed [49:0] MIN32 = -50'sd2147483648;

   function automatic logic [31:0] clamp32(input logic signed [49:0] v);
      logic [31:0] r;
      if (v > MAX32) begin
         r = 32'h7FFF_FFFF;
      end else if (v < MIN32) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   step_type          step_ff, step_in;
   logic [1:0]        axis_ff, axis_in;
   logic              tgt_ff, tgt_in;
   req_type           req_ff, req_in;
   body_rec_type      rec_a_ff, rec_a_in;
   body_rec_type      rec_b_ff, rec_b_in;
   logic signed [50:0] vn_ff, vn_in;
   logic [32:0]       inv_a_ff, inv_a_in;
   logic [33:0]       denom_ff, denom_in;
   logic [31:0]       num_ff, num_in;
   logic [30:0]       j_ff, j_in;
   logic [2:0][31:0]  p_ff, p_in;
   logic              sat_ff, sat_in;
   logic              applied_ff, applied_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0] addr_a, addr_b;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   body_rec_type      ram_wdata, ram_rdata;
   logic [REC_W-1:0]  ram_rdata_raw;

   alu_req_type       unit_req;
   alu_rsp_type       unit_rsp;

   logic [2:0][31:0]  req_vec;
   logic [31:0]       n_val, n_mag;
   logic [31:0]       va_cur, vb_cur, vt_cur;
   logic signed [32:0] rel;
   logic [32:0]       rel_mag;
   logic              mul_neg;
   logic signed [65:0] prod_s;
   logic signed [49:0] fl;
   logic signed [50:0] vn_sum;
   logic [50:0]       negvn_full;
   logic [30:0]       negvn;
   logic [16:0]       e_min;
   logic [17:0]       factor;
   logic [31:0]       mass_t;
   logic [31:0]       p_cur, push_mag;
   logic              push_neg;
   logic signed [49:0] dv, vsum;
   logic [31:0]       push_val;
   logic              push_sat;
   logic [32:0]       inv_b_val;
   logic [33:0]       denom_sum;

   cir_ram #(.WIDTH(REC_W), .DEPTH(NUM_BODIES)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );
   assign ram_rdata = ram_rdata_raw;

   cir_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (unit_req),
      .alu_rsp (unit_rsp)
   );

   assign addr_a = body_index(req_ff.body_a);
   assign addr_b = body_index(req_ff.body_b);

   // Operand preparation shared by issue and completion; inputs hold during a run.
   always_comb begin
      req_vec  = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
      n_val    = req_vec[axis_ff];
      n_mag    = n_val[31] ? (32'd0 - n_val) : n_val;
      va_cur   = rec_a_ff.vel[axis_ff];
      vb_cur   = rec_b_ff.vel[axis_ff];
      rel      = $signed({vb_cur[31], vb_cur}) - $signed({va_cur[31], va_cur});
      rel_mag  = rel[32] ? (33'd0 - rel) : rel;
      mul_neg  = (step_ff == STEP_VN) ? (rel[32] ^ n_val[31]) : n_val[31];
      prod_s   = mul_neg ? -$signed(unit_rsp.prod) : $signed(unit_rsp.prod);
      fl       = prod_s[65:16];
      vn_sum   = vn_ff + {fl[49], fl};
      negvn_full = 51'd0 - vn_ff;
      negvn    = (|negvn_full[50:31]) ? 31'h7FFF_FFFF : negvn_full[30:0];
      e_min    = (rec_a_ff.bounce < rec_b_ff.bounce) ? rec_a_ff.bounce : rec_b_ff.bounce;
      factor   = {1'b0, BOUNCE_ONE} + {1'b0, e_min};
      inv_b_val = (rec_b_ff.mass == '0) ? '0 : unit_rsp.quo[32:0];
      denom_sum = {1'b0, inv_a_ff} + {1'b0, inv_b_val};

      mass_t   = tgt_ff ? rec_b_ff.mass : rec_a_ff.mass;
      vt_cur   = tgt_ff ? vb_cur : va_cur;
      p_cur    = p_ff[axis_ff];
      if (req_ff.kind == KIND_IMPULSE) begin
         push_mag = n_mag;
         push_neg = n_val[31];
      end else begin
         push_mag = p_cur[31] ? (32'd0 - p_cur) : p_cur;
         // Body a receives the impulse with its sign turned around.
         push_neg = tgt_ff ? p_cur[31] : (!p_cur[31] && (p_cur != '0));
      end
      dv       = push_neg ? -$signed({2'b00, unit_rsp.quo}) : $signed({2'b00, unit_rsp.quo});
      vsum     = $signed({{18{vt_cur[31]}}, vt_cur}) + dv;
      push_val = clamp32(vsum);
      push_sat = (vsum > MAX32) || (vsum < MIN32);

      unit_req.start = (state_ff == S_ISSUE);
      unique case (step_ff)
         STEP_VN: begin
            unit_req.op = ALU_MUL;
            unit_req.a  = {16'd0, n_mag};
            unit_req.b  = {1'b0, rel_mag};
         end
         STEP_INV_A: begin
            unit_req.op = ALU_DIV;
            unit_req.a  = 48'h1_0000_0000;
            unit_req.b  = {2'b00, rec_a_ff.mass};
         end
         STEP_INV_B: begin
            unit_req.op = ALU_DIV;
            unit_req.a  = 48'h1_0000_0000;
            unit_req.b  = {2'b00, rec_b_ff.mass};
         end
         STEP_NUM: begin
            unit_req.op = ALU_MUL;
            unit_req.a  = {30'd0, factor};
            unit_req.b  = {3'd0, negvn};
         end
         STEP_J: begin
            unit_req.op = ALU_DIV;
            unit_req.a  = {num_ff, 16'd0};
            unit_req.b  = denom_ff;
         end
         STEP_P: begin
            unit_req.op = ALU_MUL;
            unit_req.a  = {16'd0, n_mag};
            unit_req.b  = {3'd0, j_ff};
         end
         STEP_PUSH: begin
            unit_req.op = ALU_DIV;
            unit_req.a  = {push_mag, 16'd0};
            unit_req.b  = {2'b00, mass_t};
         end
         default: begin
            unit_req.op = ALU_MUL;
            unit_req.a  = '0;
            unit_req.b  = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      tgt_in       = tgt_ff;
      req_in       = req_ff;
      rec_a_in     = rec_a_ff;
      rec_b_in     = rec_b_ff;
      vn_in        = vn_ff;
      inv_a_in     = inv_a_ff;
      denom_in     = denom_ff;
      num_in       = num_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      sat_in       = sat_ff;
      applied_in   = applied_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = addr_a;
      ram_wdata    = rec_a_ff;
      ram_re       = 1'b0;
      ram_raddr    = addr_a;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               sat_in     = 1'b0;
               applied_in = 1'b0;
               state_in   = S_RD_A;
            end
         end
         S_RD_A: begin
            ram_re    = 1'b1;
            ram_raddr = addr_a;
            state_in  = S_RD_B;
         end
         S_RD_B: begin
            ram_re    = 1'b1;
            ram_raddr = addr_b;
            rec_a_in  = ram_rdata;
            state_in  = S_GOT_B;
         end
         S_GOT_B: begin
            rec_b_in = ram_rdata;
            axis_in  = 2'd0;
            tgt_in   = 1'b0;
            unique case (req_ff.kind)
               KIND_LOAD: begin
                  rec_a_in.vel    = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
                  rec_a_in.mass   = req_ff.load_mass;
                  rec_a_in.bounce = (req_ff.load_bounce > BOUNCE_ONE) ? BOUNCE_ONE
                                                                      : req_ff.load_bounce;
                  state_in        = S_WR;
               end
               KIND_IMPULSE: begin
                  step_in  = STEP_PUSH;
                  state_in = S_ISSUE;
               end
               KIND_COLLIDE: begin
                  vn_in    = '0;
                  step_in  = STEP_VN;
                  state_in = S_ISSUE;
               end
               KIND_NONE: begin
                  state_in = S_OUT_A;
               end
            endcase
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (unit_rsp.done) begin
               unique case (step_ff)
                  STEP_VN: begin
                     vn_in = vn_sum;
                     if (axis_ff == 2'd2) begin
                        // A separating contact gets no impulse.
                        if (!vn_sum[50] && (vn_sum != '0)) begin
                           state_in = S_OUT_A;
                        end else begin
                           step_in  = STEP_INV_A;
                           state_in = S_ISSUE;
                        end
                     end else begin
                        axis_in  = axis_ff + 2'd1;
                        state_in = S_ISSUE;
                     end
                  end
                  STEP_INV_A: begin
                     inv_a_in = (rec_a_ff.mass == '0) ? '0 : unit_rsp.quo[32:0];
                     step_in  = STEP_INV_B;
                     state_in = S_ISSUE;
                  end
                  STEP_INV_B: begin
                     if (denom_sum == '0) begin
                        state_in = S_OUT_A;
                     end else begin
                        denom_in = denom_sum;
                        step_in  = STEP_NUM;
                        state_in = S_ISSUE;
                     end
                  end
                  STEP_NUM: begin
                     num_in   = unit_rsp.prod[47:16];
                     step_in  = STEP_J;
                     state_in = S_ISSUE;
                  end
                  STEP_J: begin
                     j_in     = (|unit_rsp.quo[47:31]) ? 31'h7FFF_FFFF : unit_rsp.quo[30:0];
                     axis_in  = 2'd0;
                     step_in  = STEP_P;
                     state_in = S_ISSUE;
                  end
                  STEP_P: begin
                     p_in[axis_ff] = clamp32(fl);
                     state_in      = S_ISSUE;
                     if (axis_ff == 2'd2) begin
                        applied_in = 1'b1;
                        tgt_in     = 1'b0;
                        axis_in    = 2'd0;
                        step_in    = STEP_PUSH;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
                  STEP_PUSH: begin
                     // An infinite mass takes no velocity change.
                     if (mass_t != '0) begin
                        if (tgt_ff) begin
                           rec_b_in.vel[axis_ff] = push_val;
                        end else begin
                           rec_a_in.vel[axis_ff] = push_val;
                        end
                        if (push_sat) begin
                           sat_in = 1'b1;
                        end
                     end
                     if (axis_ff == 2'd2) begin
                        state_in = S_WR;
                     end else begin
                        axis_in  = axis_ff + 2'd1;
                        state_in = S_ISSUE;
                     end
                  end
                  default: begin
                     state_in = S_OUT_A;
                  end
               endcase
            end
         end
         S_WR: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_ff ? addr_b : addr_a;
            ram_wdata = tgt_ff ? rec_b_ff : rec_a_ff;
            if ((req_ff.kind == KIND_COLLIDE) && !tgt_ff) begin
               // The same body on both sides sees the first update.
               if (addr_a == addr_b) begin
                  rec_b_in = rec_a_ff;
               end
               tgt_in   = 1'b1;
               axis_in  = 2'd0;
               step_in  = STEP_PUSH;
               state_in = S_ISSUE;
            end else begin
               state_in = S_OUT_A;
            end
         end
         S_OUT_A: begin
            ram_re    = 1'b1;
            ram_raddr = addr_a;
            state_in  = S_OUT_B;
         end
         S_OUT_B: begin
            ram_re    = 1'b1;
            ram_raddr = addr_b;
            rec_a_in  = ram_rdata;
            state_in  = S_OUT_GOT;
         end
         S_OUT_GOT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.vel_a_x   = rec_a_ff.vel[0];
               rsp_in.vel_a_y   = rec_a_ff.vel[1];
               rsp_in.vel_a_z   = rec_a_ff.vel[2];
               rsp_in.vel_b_x   = ram_rdata.vel[0];
               rsp_in.vel_b_y   = ram_rdata.vel[1];
               rsp_in.vel_b_z   = ram_rdata.vel[2];
               rsp_in.applied   = applied_ff;
               rsp_in.saturated = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_VN;
         axis_ff      <= 2'd0;
         tgt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         tgt_ff       <= tgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      rec_a_ff   <= rec_a_in;
      rec_b_ff   <= rec_b_in;
      vn_ff      <= vn_in;
      inv_a_ff   <= inv_a_in;
      denom_ff   <= denom_in;
      num_ff     <= num_in;
      j_ff       <= j_in;
      p_ff       <= p_in;
      sat_ff     <= sat_in;
      applied_ff <= applied_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> state_ff == S_WAIT) else $error("unit finished outside wait");
   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !unit_rsp.busy) else $error("ready while the unit still runs");
   a_applied_collide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_ff.applied |-> req_ff.kind == KIND_COLLIDE)
      else $error("impulse reported for a transaction that is no collision");

endmodule
